### sv/gcev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcev_pkg;

   localparam int BUTTON_COUNT = 16;

   // event slots in emission order
   localparam int SLOT_COUNT = 33;
   localparam int SLOT_CONN  = 0;
   localparam int SLOT_BTN   = 1;
   localparam int SLOT_TRIG  = 17;
   localparam int SLOT_AXIS  = 21;

   localparam logic [5:0] EV_CONNECT     = 6'd0;
   localparam logic [5:0] EV_DISCONNECT  = 6'd1;
   localparam logic [5:0] EV_BUTTON      = 6'd2;
   localparam logic [5:0] EV_TRIGGER     = 6'd18;
   localparam logic [5:0] EV_TRIG_BUTTON = 6'd20;
   localparam logic [5:0] EV_AXIS        = 6'd22;

   // first direction code of each axis: lx left, ly up, rx left, ry up
   localparam logic [3:0][5:0] DIR_BASE = {6'd30, 6'd32, 6'd26, 6'd28};

   localparam logic [14:0] DEAD_ZONE_RST   = 15'd7864;
   localparam logic [7:0]  TRIG_LEVEL_RST  = 8'd30;
   localparam logic [14:0] STICK_LEVEL_RST = 15'd25000;
   localparam logic [15:0] BTN_MASK_RST    = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_DEAD_ZONE   = 2'd0,
      CSR_TRIG_LEVEL  = 2'd1,
      CSR_STICK_LEVEL = 2'd2,
      CSR_BTN_MASK    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CHANGE  = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // everything the back end needs to play out one request
   typedef struct packed {
      logic [SLOT_COUNT-1:0] pend;
      logic                  conn_up;
      logic [15:0]           buttons;
      logic [1:0]            trig_press;
      logic [7:0]            dir_press;
      logic [1:0][7:0]       trig;
      logic [3:0][15:0]      axis;
   } job_type;

endpackage

`default_nettype wire

### sv/gcev_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface gcev_req_if;
   logic        valid;
   logic        ready;
   logic        connected;
   logic        read_ok;
   logic [31:0] packet_number;
   logic [15:0] buttons;
   logic [7:0]  left_trigger;
   logic [7:0]  right_trigger;
   logic signed [15:0] left_x;
   logic signed [15:0] left_y;
   logic signed [15:0] right_x;
   logic signed [15:0] right_y;

   modport source (
      output valid, connected, read_ok, packet_number, buttons, left_trigger,
             right_trigger, left_x, left_y, right_x, right_y,
      input  ready
   );
   modport sink (
      input  valid, connected, read_ok, packet_number, buttons, left_trigger,
             right_trigger, left_x, left_y, right_x, right_y,
      output ready
   );
endinterface

interface gcev_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  event_code;
   logic [1:0]  event_kind;
   logic signed [15:0] event_value;
   logic        last_event;

   modport source (
      output valid, event_code, event_kind, event_value, last_event,
      input  ready
   );
   modport sink (
      input  valid, event_code, event_kind, event_value, last_event,
      output ready
   );
endinterface

`default_nettype wire

### sv/gcev_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gcev_front
   import gcev_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   gcev_req_if.sink         req_chan,
   input  wire logic        q_full,
   output logic             q_push,
   output job_type          q_job
);

   logic [14:0] dead_zone_ff, dead_zone_in;
   logic [7:0]  trig_level_ff, trig_level_in;
   logic [14:0] stick_level_ff, stick_level_in;
   logic [15:0] btn_mask_ff, btn_mask_in;

   logic             was_conn_ff, was_conn_in;
   logic [31:0]      last_pkt_ff, last_pkt_in;
   logic [15:0]      last_btn_ff, last_btn_in;
   logic [1:0][7:0]  last_trig_ff, last_trig_in;
   logic [3:0][15:0] last_axis_ff, last_axis_in;

   logic             accept;
   logic             take;
   logic [1:0][7:0]  trig_new;
   logic [3:0][15:0] axis_raw;
   logic [3:0][15:0] axis_new;
   logic [15:0]      btn_chg;
   logic [15:0]      count_mask;
   logic [3:0]       axis_small;
   logic signed [16:0] dz17, st17;
   job_type          job;

   // returns {fire, press} for one direction, axis already mirrored
   function automatic logic [1:0] dir_eval(logic signed [16:0] p, logic signed [16:0] c,
                                           logic signed [16:0] t);
      logic rel;
      logic prs;
      rel = (p >= t) && (c < t);
      prs = (p <= t) && (c > t);
      return {rel | prs, !rel};
   endfunction

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign take           = req_chan.connected && req_chan.read_ok
                           && (req_chan.packet_number != last_pkt_ff);

   assign trig_new = {req_chan.right_trigger, req_chan.left_trigger};
   assign axis_raw = {req_chan.right_y, req_chan.right_x, req_chan.left_y, req_chan.left_x};
   assign dz17     = $signed({2'b00, dead_zone_ff});
   assign st17     = $signed({2'b00, stick_level_ff});

   always_comb begin
      dead_zone_in   = dead_zone_ff;
      trig_level_in  = trig_level_ff;
      stick_level_in = stick_level_ff;
      btn_mask_in    = btn_mask_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEAD_ZONE:   dead_zone_in   = csr_wdata[14:0];
            CSR_TRIG_LEVEL:  trig_level_in  = csr_wdata[7:0];
            CSR_STICK_LEVEL: stick_level_in = csr_wdata[14:0];
            CSR_BTN_MASK:    btn_mask_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // dead zone: a stick is zeroed when both axes sit inside it
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         axis_small[a] = ($signed({axis_raw[a][15], axis_raw[a]}) <= dz17)
                         && ($signed({axis_raw[a][15], axis_raw[a]}) >= -dz17);
      end
      for (int s = 0; s < 2; s++) begin
         if (axis_small[2*s] && axis_small[2*s+1]) begin
            axis_new[2*s]   = '0;
            axis_new[2*s+1] = '0;
         end else begin
            axis_new[2*s]   = axis_raw[2*s];
            axis_new[2*s+1] = axis_raw[2*s+1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         count_mask[i] = (i < BUTTON_COUNT);
      end
      btn_chg = (last_btn_ff ^ req_chan.buttons) & btn_mask_ff & count_mask;
   end

   always_comb begin
      logic signed [16:0] pv;
      logic signed [16:0] cv;
      logic [1:0]         pos_ev;
      logic [1:0]         neg_ev;
      logic               chg;
      logic               now_p;
      logic               was_p;

      job            = '0;
      job.conn_up    = req_chan.connected;
      job.buttons    = req_chan.buttons;
      job.trig       = trig_new;
      job.axis       = axis_new;
      job.pend[SLOT_CONN] = (req_chan.connected != was_conn_ff);

      for (int i = 0; i < 16; i++) begin
         job.pend[SLOT_BTN+i] = take && btn_chg[i];
      end

      for (int t = 0; t < 2; t++) begin
         chg   = (trig_new[t] != last_trig_ff[t]);
         now_p = (trig_new[t] > trig_level_ff);
         was_p = (last_trig_ff[t] > trig_level_ff);
         job.trig_press[t]        = now_p;
         job.pend[SLOT_TRIG+2*t]   = take && chg;
         job.pend[SLOT_TRIG+2*t+1] = take && chg && (now_p != was_p);
      end

      for (int a = 0; a < 4; a++) begin
         pv     = $signed({last_axis_ff[a][15], last_axis_ff[a]});
         cv     = $signed({axis_new[a][15], axis_new[a]});
         chg    = (axis_new[a] != last_axis_ff[a]);
         pos_ev = dir_eval(pv, cv, st17);
         neg_ev = dir_eval(-pv, -cv, st17);
         job.pend[SLOT_AXIS+3*a] = take && chg;
         // x axes go negative then positive, y axes positive then negative
         if ((a % 2) == 0) begin
            job.pend[SLOT_AXIS+3*a+1] = take && chg && neg_ev[1];
            job.dir_press[2*a]        = neg_ev[0];
            job.pend[SLOT_AXIS+3*a+2] = take && chg && pos_ev[1];
            job.dir_press[2*a+1]      = pos_ev[0];
         end else begin
            job.pend[SLOT_AXIS+3*a+1] = take && chg && pos_ev[1];
            job.dir_press[2*a]        = pos_ev[0];
            job.pend[SLOT_AXIS+3*a+2] = take && chg && neg_ev[1];
            job.dir_press[2*a+1]      = neg_ev[0];
         end
      end
   end

   assign q_job  = job;
   assign q_push = accept && (|job.pend);

   always_comb begin
      was_conn_in  = was_conn_ff;
      last_pkt_in  = last_pkt_ff;
      last_btn_in  = last_btn_ff;
      last_trig_in = last_trig_ff;
      last_axis_in = last_axis_ff;
      if (accept) begin
         was_conn_in = req_chan.connected;
         if (take) begin
            last_pkt_in  = req_chan.packet_number;
            last_btn_in  = req_chan.buttons;
            last_trig_in = trig_new;
            last_axis_in = axis_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff   <= DEAD_ZONE_RST;
         trig_level_ff  <= TRIG_LEVEL_RST;
         stick_level_ff <= STICK_LEVEL_RST;
         btn_mask_ff    <= BTN_MASK_RST;
         was_conn_ff    <= 1'b0;
         last_pkt_ff    <= '0;
         last_btn_ff    <= '0;
         last_trig_ff   <= '0;
         last_axis_ff   <= '0;
      end else begin
         dead_zone_ff   <= dead_zone_in;
         trig_level_ff  <= trig_level_in;
         stick_level_ff <= stick_level_in;
         btn_mask_ff    <= btn_mask_in;
         was_conn_ff    <= was_conn_in;
         last_pkt_ff    <= last_pkt_in;
         last_btn_ff    <= last_btn_in;
         last_trig_ff   <= last_trig_in;
         last_axis_ff   <= last_axis_in;
      end
   end

endmodule

`default_nettype wire

### sv/gcev_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gcev_queue
   import gcev_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   input  wire logic pop,
   output logic      full,
   output logic      head_valid,
   output job_type   head_job
);

   job_type    slot_ff [2];
   job_type    slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_job;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/gcev_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gcev_back
   import gcev_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic head_valid,
   input  job_type   head_job,
   output logic      pop,
   gcev_rsp_if.source rsp_chan
);

   logic            busy_ff, busy_in;
   job_type         job_ff, job_in;
   logic            out_vld_ff, out_vld_in;
   logic [5:0]      code_ff, code_in;
   kind_type        kind_ff, kind_in;
   logic [15:0]     value_ff, value_in;
   logic            last_ff, last_in;

   logic                  advance;
   logic [SLOT_COUNT-1:0] sel;
   logic [SLOT_COUNT-1:0] rest;

   assign advance = busy_ff && (!out_vld_ff || rsp_chan.ready);
   // lowest pending slot goes next
   assign sel     = job_ff.pend & (~job_ff.pend + SLOT_COUNT'(1));
   assign rest    = job_ff.pend & ~sel;

   always_comb begin
      code_in  = EV_CONNECT;
      kind_in  = KIND_CHANGE;
      value_in = '0;
      last_in  = (rest == '0);
      if (sel[SLOT_CONN]) begin
         code_in = job_ff.conn_up ? EV_CONNECT : EV_DISCONNECT;
      end
      for (int i = 0; i < 16; i++) begin
         if (sel[SLOT_BTN+i]) begin
            code_in = EV_BUTTON + 6'(i);
            kind_in = job_ff.buttons[i] ? KIND_PRESS : KIND_RELEASE;
         end
      end
      for (int t = 0; t < 2; t++) begin
         if (sel[SLOT_TRIG+2*t]) begin
            code_in  = EV_TRIGGER + 6'(t);
            value_in = {8'b0, job_ff.trig[t]};
         end
         if (sel[SLOT_TRIG+2*t+1]) begin
            code_in = EV_TRIG_BUTTON + 6'(t);
            kind_in = job_ff.trig_press[t] ? KIND_PRESS : KIND_RELEASE;
         end
      end
      for (int a = 0; a < 4; a++) begin
         if (sel[SLOT_AXIS+3*a]) begin
            code_in  = EV_AXIS + 6'(a);
            value_in = job_ff.axis[a];
         end
         if (sel[SLOT_AXIS+3*a+1]) begin
            code_in = DIR_BASE[a];
            kind_in = job_ff.dir_press[2*a] ? KIND_PRESS : KIND_RELEASE;
         end
         if (sel[SLOT_AXIS+3*a+2]) begin
            code_in = DIR_BASE[a] + 6'd1;
            kind_in = job_ff.dir_press[2*a+1] ? KIND_PRESS : KIND_RELEASE;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      pop     = 1'b0;
      if (!busy_ff || (advance && (rest == '0))) begin
         // pick up the next request as soon as this one runs dry
         busy_in = head_valid;
         job_in  = head_job;
         pop     = head_valid;
      end else if (advance) begin
         job_in.pend = rest;
      end
   end

   always_comb begin
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         code_ff  <= code_in;
         kind_ff  <= kind_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.event_code  = code_ff;
   assign rsp_chan.event_kind  = kind_ff;
   assign rsp_chan.event_value = $signed(value_ff);
   assign rsp_chan.last_event  = last_ff;

endmodule

`default_nettype wire

### sv/gamepad_change_event_generator.sv
// a request's first event passes the queue slot, job register and output register
// throughput: one event per cycle out of the back end while the receiver holds ready;
//   a request causes at most 33 events, and one with no events never enters the queue
// the request side takes one request per cycle until the two-entry queue is full
// reset (synchronous, active high) restores the register defaults and clears the
//   stored snapshot, connection flag, queue and output
`timescale 1ns / 1ps
`default_nettype none

module gamepad_change_event_generator
   import gcev_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   gcev_req_if.sink         req_chan,
   gcev_rsp_if.source       rsp_chan
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_head_valid;
   job_type q_push_job;
   job_type q_head_job;

   gcev_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_push_job)
   );

   gcev_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   gcev_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
